@@ design/zmpref_pkg.sv @@
package zmpref_pkg;

  localparam int SAMPLE_W = 24;
  localparam int POS_W = 32;
  localparam int IDX_W = 6;
  localparam int CFG_W = 16;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int ALPHA_W = 17;

  localparam int MAX_STEPS_DEF = 64;
  localparam int BLEND_ENTRIES_DEF = 256;

  localparam real PI = 3.14159265358979323846;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DSP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd3;

  localparam logic [CFG_W-1:0] FIRST_RST = 16'd200;
  localparam logic [CFG_W-1:0] STEP_RST = 16'd160;
  localparam logic [CFG_W-1:0] DSP_RST = 16'd20;
  localparam logic [COUNT_W-1:0] COUNT_RST = 7'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_FIRST,
    KIND_LATER
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [SAMPLE_W-1:0] r;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] first;
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] dsp;
    logic [COUNT_W-1:0] count;
  } cfg_t;

endpackage

@@ design/zmpref_ram.sv @@
module zmpref_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/zmpref_div.sv @@
module zmpref_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] part;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [DEN_W:0] trial;
  logic ge;

  // one quotient bit per cycle, restoring
  assign trial = {part, acc[NUM_W-1]};
  assign ge = trial >= {1'b0, dvs};
  assign quot = acc;
  assign rem = part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc <= num;
        part <= '0;
        dvs <= den;
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        acc <= {acc[NUM_W-2:0], ge};
        part <= ge ? DEN_W'(trial - {1'b0, dvs}) : DEN_W'(trial);
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/zmpref_front.sv @@
module zmpref_front (
  input  logic                             clk,
  input  logic                             rst,
  input  zmpref_pkg::cfg_t                 cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [zmpref_pkg::IDX_W-1:0]     step_index,
  input  logic signed [zmpref_pkg::POS_W-1:0] foot_x,
  input  logic signed [zmpref_pkg::POS_W-1:0] foot_y,
  input  logic [zmpref_pkg::SAMPLE_W-1:0]  sample_index,
  output logic                             q_valid,
  output zmpref_pkg::entry_t               q_entry,
  input  logic                             q_pop
);

  zmpref_pkg::entry_t slot [2];
  zmpref_pkg::entry_t cls;
  logic [1:0] fill;
  logic wp;
  logic rp;
  logic push;

  assign in_ready = fill != 2'd2;
  assign push = in_valid && in_ready;
  assign q_valid = fill != 2'd0;
  assign q_entry = slot[rp];

  // classify on entry: write, first step, or a later step with its offset
  always_comb begin
    cls.idx = step_index;
    cls.x = foot_x;
    cls.y = foot_y;
    cls.r = sample_index - zmpref_pkg::SAMPLE_W'(cfg.first);
    if (opcode == zmpref_pkg::OP_WRITE) begin
      cls.kind = zmpref_pkg::KIND_WRITE;
    end else if (sample_index < zmpref_pkg::SAMPLE_W'(cfg.first)) begin
      cls.kind = zmpref_pkg::KIND_FIRST;
    end else begin
      cls.kind = zmpref_pkg::KIND_LATER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (push) begin
        slot[wp] <= cls;
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ design/zmpref_back.sv @@
module zmpref_back #(
  parameter int MAX_STEPS = zmpref_pkg::MAX_STEPS_DEF,
  parameter int BLEND_ENTRIES = zmpref_pkg::BLEND_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  zmpref_pkg::cfg_t                    cfg,
  input  logic                                q_valid,
  input  zmpref_pkg::entry_t                  q_entry,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [zmpref_pkg::POS_W-1:0] ref_x,
  output logic signed [zmpref_pkg::POS_W-1:0] ref_y
);

  localparam int AW = $clog2(MAX_STEPS);
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int EW = $clog2(BLEND_ENTRIES);
  localparam int PW = zmpref_pkg::POS_W;
  localparam int CW = zmpref_pkg::CFG_W;
  localparam int NUM_W = (zmpref_pkg::SAMPLE_W > CW + EW) ? zmpref_pkg::SAMPLE_W : CW + EW;
  localparam int AL_W = zmpref_pkg::ALPHA_W;
  localparam int PROD_W = PW + 1 + AL_W + 1;
  localparam real ANGLE_STEP = zmpref_pkg::PI / (2.0 * BLEND_ENTRIES);

  typedef logic [AL_W-1:0] alpha_rom_t [BLEND_ENTRIES];

  // round(65536 * sin^2(pi * m / (2 * entries)))
  function automatic alpha_rom_t build_alpha();
    alpha_rom_t rom;
    real s;
    for (int i = 0; i < BLEND_ENTRIES; i++) begin
      s = $sin(ANGLE_STEP * i);
      rom[i] = AL_W'($rtoi(65536.0 * s * s + 0.5));
    end
    return rom;
  endfunction

  localparam alpha_rom_t ALPHA_ROM = build_alpha();

  typedef enum logic [3:0] {
    S_IDLE, S_DIV1, S_HOLD_W, S_HOLD, S_PREV_W, S_PREV, S_DIV2, S_MUL, S_ADD, S_OUT
  } state_t;

  state_t state;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] curr_addr;
  logic [2*PW-1:0] rd_data;
  logic [CW-1:0] phase;
  logic signed [PW-1:0] prev_x, prev_y, curr_x, curr_y, res_x, res_y;
  logic [AL_W-1:0] alpha;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [PW:0] dx, dy;

  logic ram_we;
  logic div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [CW-1:0] div_den, div_rem, len;
  logic [NUM_W:0] step;
  logic [NW-1:0] n_eff;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign ram_we = q_pop && (q_entry.kind == zmpref_pkg::KIND_WRITE)
                  && (32'(q_entry.idx) < 32'(MAX_STEPS));
  assign len = (cfg.len == '0) ? CW'(1) : cfg.len;
  assign step = {1'b0, div_quot} + 1'b1;
  assign dx = (PW + 1)'(curr_x) - (PW + 1)'(prev_x);
  assign dy = (PW + 1)'(curr_y) - (PW + 1)'(prev_y);

  always_comb begin
    if (cfg.count == '0) begin
      n_eff = NW'(1);
    end else if (32'(cfg.count) > 32'(MAX_STEPS)) begin
      n_eff = NW'(MAX_STEPS);
    end else begin
      n_eff = NW'(cfg.count);
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num = NUM_W'(q_entry.r);
    div_den = len;
    if (state == S_IDLE) begin
      div_start = q_pop && (q_entry.kind == zmpref_pkg::KIND_LATER);
    end else if (state == S_PREV) begin
      div_start = 1'b1;
      div_num = NUM_W'(32'(phase) * 32'(BLEND_ENTRIES));
      div_den = cfg.dsp;
    end
  end

  zmpref_ram #(.WIDTH(2 * PW), .DEPTH(MAX_STEPS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(q_entry.idx)),
    .wdata ({q_entry.x, q_entry.y}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  zmpref_div #(.NUM_W(NUM_W), .DEN_W(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_entry.kind)
              zmpref_pkg::KIND_WRITE: begin
                res_x <= '0;
                res_y <= '0;
                state <= S_OUT;
              end
              zmpref_pkg::KIND_FIRST: begin
                rd_addr <= '0;
                state <= S_HOLD_W;
              end
              default: state <= S_DIV1;
            endcase
          end
        end
        S_DIV1: begin
          if (div_done) begin
            if (33'(step) >= 33'(n_eff)) begin
              rd_addr <= AW'(n_eff - 1'b1);
              state <= S_HOLD_W;
            end else if (div_rem < cfg.dsp) begin
              phase <= div_rem;
              rd_addr <= AW'(div_quot);
              curr_addr <= AW'(step);
              state <= S_PREV_W;
            end else begin
              rd_addr <= AW'(step);
              state <= S_HOLD_W;
            end
          end
        end
        S_HOLD_W: state <= S_HOLD;
        S_HOLD: begin
          res_x <= rd_data[2*PW-1:PW];
          res_y <= rd_data[PW-1:0];
          state <= S_OUT;
        end
        S_PREV_W: state <= S_PREV;
        S_PREV: begin
          prev_x <= rd_data[2*PW-1:PW];
          prev_y <= rd_data[PW-1:0];
          rd_addr <= curr_addr;
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            curr_x <= rd_data[2*PW-1:PW];
            curr_y <= rd_data[PW-1:0];
            alpha <= ALPHA_ROM[div_quot[EW-1:0]];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_x <= dx * $signed({1'b0, alpha});
          prod_y <= dy * $signed({1'b0, alpha});
          state <= S_ADD;
        end
        S_ADD: begin
          // arithmetic shift by 16 keeps the floor of the scaled difference
          res_x <= prev_x + prod_x[PW+15:16];
          res_y <= prev_y + prod_y[PW+15:16];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            ref_x <= res_x;
            ref_y <= res_y;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/zmp_reference_generator.sv @@
// zmp reference generator: write transactions (opcode 0) load one footstep
// (x, y in Q15.16) into the table and return a zero result; query transactions
// return the reference ZMP for one sample index, holding footstep 0 during the
// first step, then for each later step a cosine blend from the previous
// footstep over the first samples of the step (as many as the blend length
// register gives) and the footstep itself after.
// every transaction gives exactly one result. timing is set by the bit-serial
// divider (one quotient bit per cycle, for a quotient of max(24, 16 + log2 of
// the blend table size) bits, 24 at the default sizes) and by the single read
// port of the footstep memory. transactions are handled one at a time by the
// back end; a two-entry queue in front keeps accepting while the back end
// works, and an output register holds a finished result while the next
// transaction starts. configuration is to be written only while the block is
// idle; the user is bound by this, the block itself does not enforce it.
module zmp_reference_generator #(
  parameter int MAX_STEPS = zmpref_pkg::MAX_STEPS_DEF,
  parameter int BLEND_ENTRIES = zmpref_pkg::BLEND_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [zmpref_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [zmpref_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 opcode,
  input  logic [zmpref_pkg::IDX_W-1:0]         step_index,
  input  logic signed [zmpref_pkg::POS_W-1:0]  foot_x,
  input  logic signed [zmpref_pkg::POS_W-1:0]  foot_y,
  input  logic [zmpref_pkg::SAMPLE_W-1:0]      sample_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [zmpref_pkg::POS_W-1:0]  ref_x,
  output logic signed [zmpref_pkg::POS_W-1:0]  ref_y
);

  zmpref_pkg::cfg_t cfg;
  zmpref_pkg::entry_t q_entry;
  logic q_valid;
  logic q_pop;

  // configuration registers; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first <= zmpref_pkg::FIRST_RST;
      cfg.len <= zmpref_pkg::STEP_RST;
      cfg.dsp <= zmpref_pkg::DSP_RST;
      cfg.count <= zmpref_pkg::COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        zmpref_pkg::CFG_FIRST: cfg.first <= cfg_data;
        zmpref_pkg::CFG_STEP:  cfg.len <= cfg_data;
        zmpref_pkg::CFG_DSP:   cfg.dsp <= cfg_data;
        zmpref_pkg::CFG_COUNT: cfg.count <= cfg_data[zmpref_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: classification and the transaction queue
  zmpref_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .step_index   (step_index),
    .foot_x       (foot_x),
    .foot_y       (foot_y),
    .sample_index (sample_index),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop)
  );

  // back end: footstep memory, divider, blend and the output register
  zmpref_back #(
    .MAX_STEPS     (MAX_STEPS),
    .BLEND_ENTRIES (BLEND_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ref_x     (ref_x),
    .ref_y     (ref_y)
  );

`ifndef ASSERT_OFF
  // the back end only takes from a queue that holds something
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // the queue only fills up through an accepted transaction
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("queue became full without a transaction");

  // no result is shown straight after reset
  a_rst_out: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

@@ tb/zmp_checker.sv @@
`timescale 1ns / 1ps

module zmp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        opcode,
  input  logic [5:0]  step_index,
  input  logic [31:0] foot_x,
  input  logic [31:0] foot_y,
  input  logic [23:0] sample_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] ref_x,
  input  logic [31:0] ref_y,
  output int          fail_count,
  output int          pending
);

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

  logic [15:0] first_len, later_len, blend_len;
  logic [6:0]  foot_count;
  logic [31:0] foot_x_mem [64];
  logic [31:0] foot_y_mem [64];
  logic [63:0] zmp_due [$];

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[125:62];
  endfunction

  // sin^2 ramp weight, rounded to 16 fraction bits
  function automatic logic [63:0] ramp_weight(logic [63:0] m);
    logic [63:0] u, u2, term, acc;
    u = (PI_Q62 / 512) * m + ((PI_Q62 % 512) * m) / 512;
    u2 = q62_mul(u, u);
    term = u;
    acc = u;
    for (int k = 1; k <= 14; k++) begin
      term = q62_mul(term, u2) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return (q62_mul(acc, acc) + (64'd1 << 45)) >> 46;
  endfunction

  function automatic logic [31:0] ramp_pos(logic [31:0] a, logic [31:0] b, logic [63:0] w);
    longint p, d, q;
    logic [63:0] mag;
    p = longint'(signed'(a));
    d = longint'(signed'(b)) - p;
    if (d >= 0) begin
      mag = 64'(d) * w;
      q = longint'(mag >> 16);
    end else begin
      mag = 64'(-d) * w;
      q = -longint'((mag + 64'd65535) >> 16);
    end
    return 32'(p + q);
  endfunction

  function automatic logic [63:0] zmp_of(logic [23:0] s);
    longint unsigned n, len, r, stp, ph, m, w;
    n = (foot_count == 0) ? 1 : foot_count;
    if (n > 64) n = 64;
    len = (later_len == 0) ? 1 : later_len;
    if (s < first_len) return {foot_x_mem[0], foot_y_mem[0]};
    r = s - first_len;
    stp = 1 + r / len;
    ph = r % len;
    if (stp >= n) return {foot_x_mem[n-1], foot_y_mem[n-1]};
    if (ph < blend_len) begin
      m = ph * 256 / blend_len;
      w = ramp_weight(m);
      return {ramp_pos(foot_x_mem[stp-1], foot_x_mem[stp], w),
              ramp_pos(foot_y_mem[stp-1], foot_y_mem[stp], w)};
    end
    return {foot_x_mem[stp], foot_y_mem[stp]};
  endfunction

  assign pending = zmp_due.size();

  always @(posedge clk) begin
    logic [63:0] want;
    if (rst) begin
      first_len <= zmpref_pkg::FIRST_RST;
      later_len <= zmpref_pkg::STEP_RST;
      blend_len <= zmpref_pkg::DSP_RST;
      foot_count <= zmpref_pkg::COUNT_RST;
      fail_count <= 0;
      zmp_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          zmpref_pkg::CFG_FIRST: first_len <= cfg_data;
          zmpref_pkg::CFG_STEP:  later_len <= cfg_data;
          zmpref_pkg::CFG_DSP:   blend_len <= cfg_data;
          zmpref_pkg::CFG_COUNT: foot_count <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (opcode == zmpref_pkg::OP_WRITE) begin
          foot_x_mem[step_index] = foot_x;
          foot_y_mem[step_index] = foot_y;
          zmp_due.push_back(64'd0);
        end else begin
          zmp_due.push_back(zmp_of(sample_index));
        end
      end
      if (out_valid && out_ready) begin
        if (zmp_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result x=%h y=%h", ref_x, ref_y);
        end else begin
          want = zmp_due.pop_front();
          if (want != {ref_x, ref_y}) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected x=%h y=%h, got x=%h y=%h",
                       want[63:32], want[31:0], ref_x, ref_y);
          end
        end
      end
    end
  end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_ready, opcode;
  logic [5:0]  step_index;
  logic [31:0] foot_x, foot_y;
  logic [23:0] sample_index;
  logic        out_valid, out_ready;
  logic [31:0] ref_x, ref_y;
  int          fail_count, pending;
  int          quiet_cycles;
  bit          calm;     // no idling on either side while set
  int          foot_n;   // footsteps written in this phase
  logic [15:0] cur_first, cur_len;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  zmp_reference_generator dut (.*);

  zmp_checker chk (.*);

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
  end

  task automatic send(input logic op, input logic [5:0] idx, input logic [31:0] x,
                      input logic [31:0] y, input logic [23:0] s);
    while (!calm && $urandom_range(99) < 32) @(negedge clk);
    in_valid = 1;
    opcode = op;
    step_index = idx;
    foot_x = x;
    foot_y = y;
    sample_index = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  // wait for every result, then let the back end drain before a register write
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] v);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // fill entries 0..n-1 so no query reads an unwritten entry
  task automatic load_steps(input int n);
    for (int i = 0; i < n; i++)
      send(zmpref_pkg::OP_WRITE, 6'(i), $urandom, $urandom, 24'($urandom));
    foot_n = n;
  endtask

  task automatic configure(input logic [15:0] f, input logic [15:0] l,
                           input logic [15:0] d, input logic [6:0] c);
    drain();
    set_reg(zmpref_pkg::CFG_FIRST, f);
    set_reg(zmpref_pkg::CFG_STEP, l);
    set_reg(zmpref_pkg::CFG_DSP, d);
    set_reg(zmpref_pkg::CFG_COUNT, {9'd0, c});
    cur_first = f;
    cur_len = l;
  endtask

  // query mostly inside the span of the steps in use
  task automatic random_query();
    int unsigned span;
    span = cur_first + foot_n * ((cur_len == 0) ? 1 : cur_len) + 50;
    if ($urandom_range(9) == 0)
      send(zmpref_pkg::OP_QUERY, 6'($urandom), $urandom, $urandom, 24'($urandom));
    else
      send(zmpref_pkg::OP_QUERY, 6'($urandom), $urandom, $urandom,
           24'($urandom_range(span)));
  endtask

  initial begin
    rst = 1;
    calm = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; opcode = 0; step_index = 0;
    foot_x = 0; foot_y = 0; sample_index = 0;
    out_ready = 0;
    foot_n = 0;
    cur_first = zmpref_pkg::FIRST_RST;
    cur_len = zmpref_pkg::STEP_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: reset settings, extreme positions, blend ends
    send(zmpref_pkg::OP_WRITE, 6'd0, 32'h8000_0000, 32'h7fff_ffff, 24'hffffff);
    send(zmpref_pkg::OP_QUERY, 6'h3f, 0, 0, 24'd0);
    send(zmpref_pkg::OP_QUERY, 6'd0, 0, 0, 24'hffffff);
    configure(16'd4, 16'd8, 16'd8, 7'd64);
    load_steps(64);
    send(zmpref_pkg::OP_WRITE, 6'd1, 32'h7fff_ffff, 32'h8000_0000, 0);
    send(zmpref_pkg::OP_WRITE, 6'd2, 32'h8000_0000, 32'h7fff_ffff, 0);
    for (int s = 3; s < 24; s += 2) send(zmpref_pkg::OP_QUERY, 0, 0, 0, 24'(s));
    // pause until the block is empty
    drain();
    send(zmpref_pkg::OP_QUERY, 0, 0, 0, 24'd1000);

    // step count zero, zero lengths, no blend, blend longer than step, extremes
    configure(16'd0, 16'd0, 16'd0, 7'd0);
    for (int i = 0; i < 6; i++) random_query();
    configure(16'd0, 16'd3, 16'd65535, 7'd127);
    for (int i = 0; i < 20; i++) random_query();
    configure(16'd65535, 16'd65535, 16'd65535, 7'd64);
    for (int i = 0; i < 20; i++) random_query();

    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      logic [15:0] l;
      l = 16'($urandom_range(1, 300));
      configure(16'($urandom_range(0, 300)), l, 16'($urandom_range(0, l)),
                7'($urandom_range(1, 64)));
      calm = (ph == 3);
      load_steps($urandom_range(2, 64));
      for (int i = 0; i < 45; i++) begin
        if ($urandom_range(9) == 0)
          send(zmpref_pkg::OP_WRITE, 6'($urandom_range(foot_n - 1)),
               $urandom, $urandom, 24'($urandom));
        else random_query();
      end
    end
    calm = 0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
